// ===== hdl/task_latency_deadline_monitor_macros.svh =====
// Assertion macros for the task latency deadline monitor.
// Depends on the including module having ports named aclk and aresetn.
`ifndef TASK_LATENCY_DEADLINE_MONITOR_MACROS_SVH
`define TASK_LATENCY_DEADLINE_MONITOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLDM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define TLDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TLDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tldm_pkg.sv =====
// Package for the task latency deadline monitor: window constants and payload types.
// No dependencies.
`timescale 1ns / 1ps

package tldm_pkg;

    // Number of latency samples in one averaging window (1 or more).
    localparam int WINDOW = 100;

    // Width of the sample counter and of the division remainder.
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Reciprocal for an exact 32-bit divide by WINDOW: q = (x * RECIP) >> SHIFT.
    localparam int SHIFT   = 32 + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int RECIP_W = 33;
    localparam logic [64:0] RECIP_FULL = ((65'd1 << SHIFT) + 65'(WINDOW) - 65'd1) / 65'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = 32 + RECIP_W;

    localparam logic [31:0]      WINDOW_32 = 32'(WINDOW);
    localparam logic [IDX_W:0]   WINDOW_R  = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW - 1);

    localparam logic [15:0] JITTER_MAX = 16'hFFFF;
    localparam logic [7:0]  MISS_MAX   = 8'hFF;

    typedef struct packed {
        logic [31:0] start_stamp;
        logic [31:0] end_stamp;
        logic [31:0] deadline;
    } in_t;

    typedef struct packed {
        logic [31:0] latency;
        logic [31:0] worst_latency;
        logic [31:0] mean_latency;
        logic [15:0] jitter_peak;
        logic [7:0]  miss_count;
        logic        missed;
        logic        window_done;
    } out_t;

endpackage

// ===== hdl/task_latency_deadline_monitor.sv =====
// Task latency deadline monitor: latency, worst case, windowed mean, jitter peak, misses.
// Depends on tldm_pkg and task_latency_deadline_monitor_macros.svh.
// Throughput: one transaction per cycle while the output is not stalled.
// The only loop is the state update in the last stage.
// Reset: synchronous, active low aresetn clears all statistics and the pipeline valid bits.
// There is no clearing pass; the block accepts input in the first cycle after reset.
`timescale 1ns / 1ps
`include "task_latency_deadline_monitor_macros.svh"

module task_latency_deadline_monitor (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tldm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tldm_pkg::out_t m_data
);

    // Pipeline overview:
    //   stage 0  input register holding the raw timestamps and deadline.
    //   stage 1  latency (end minus start, wrapping) and the deadline miss flag.
    //   stage 2  product of the latency and the reciprocal of WINDOW.
    //   stage 3  latency split into quotient and remainder by WINDOW.
    //   result   statistics update and the output register.
    // The running window sum is kept as a quotient and a remainder by WINDOW, so the
    // mean at the end of a window is just the quotient and no wide divider is needed.
    // Every stage advances when the stage after it is empty or moving, so a stalled
    // output never blocks stages that still hold bubbles.

    // Stage valid bits and load enables.
    logic v0_reg, v1_reg, v2_reg, v3_reg, mv_reg;
    logic ld0, ld1, ld2, ld3, ld_out;

    // Stage payloads.
    tldm_pkg::in_t                   in0_reg;
    logic [31:0]                     lat1_reg, lat2_reg, lat3_reg;
    logic                            miss1_reg, miss2_reg, miss3_reg;
    logic [tldm_pkg::PROD_W-1:0]     prod2_reg;
    logic [31:0]                     quo3_reg;
    logic [tldm_pkg::IDX_W-1:0]      rem3_reg;

    // Statistics state.
    logic [31:0]                worst_reg, worst_next;
    logic [31:0]                mean_reg, mean_next;
    logic [15:0]                jitter_reg, jitter_next;
    logic [7:0]                 miss_cnt_reg, miss_cnt_next;
    logic [31:0]                quo_reg, quo_next;
    logic [tldm_pkg::IDX_W-1:0] rem_reg, rem_next;
    logic [tldm_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    tldm_pkg::out_t out_reg, out_next;

    // Combinational helpers.
    logic [31:0]                lat_next;
    logic                       miss_next;
    logic [tldm_pkg::PROD_W-1:0] prod_next;
    logic [tldm_pkg::PROD_W-1:0] prod_shifted;
    logic [31:0]                quo_part;
    logic [31:0]                quo_scaled;
    logic [31:0]                rem_diff;
    logic [tldm_pkg::IDX_W:0]   rem_sum;
    logic                       rem_carry;
    logic [31:0]                quo_sum;
    logic                       done;
    logic [31:0]                mean_eff;
    logic [31:0]                dev;
    logic [15:0]                dev_sat;

    // Handshake: each stage takes new data when it is empty or its content moves on.
    assign ld_out  = !mv_reg || m_ready;
    assign ld3     = !v3_reg || ld_out;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign ld0     = !v0_reg || ld1;
    assign s_ready = ld0;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    // Stage 0 to 1: wrapping latency and the miss flag (equal to the deadline is not a miss).
    assign lat_next  = in0_reg.end_stamp - in0_reg.start_stamp;
    assign miss_next = lat_next > in0_reg.deadline;

    // Stage 1 to 2: one 32 by 33 bit multiply by the reciprocal of WINDOW.
    assign prod_next = {{tldm_pkg::RECIP_W{1'b0}}, lat1_reg} *
                       {{32{1'b0}}, tldm_pkg::RECIP};

    // Stage 2 to 3: quotient from the product, remainder by back-multiplying.
    // The remainder is below WINDOW, so the wrapped 32-bit difference is exact.
    assign prod_shifted = prod2_reg >> tldm_pkg::SHIFT;
    assign quo_part     = prod_shifted[31:0];
    assign quo_scaled   = quo_part * tldm_pkg::WINDOW_32;
    assign rem_diff     = lat2_reg - quo_scaled;

    // Result stage: accumulate the quotient and remainder of the window sum.
    assign rem_sum   = {1'b0, rem_reg} + {1'b0, rem3_reg};
    assign rem_carry = rem_sum >= tldm_pkg::WINDOW_R;
    assign quo_sum   = quo_reg + quo3_reg + {31'd0, rem_carry};
    assign done      = cnt_reg == tldm_pkg::LAST_IDX;

    // The completing item already sees the new mean.
    assign mean_eff = done ? quo_sum : mean_reg;
    assign dev      = (lat3_reg > mean_eff) ? (lat3_reg - mean_eff) : (mean_eff - lat3_reg);
    assign dev_sat  = (dev[31:16] != 16'd0) ? tldm_pkg::JITTER_MAX : dev[15:0];

    always_comb begin
        worst_next    = (lat3_reg > worst_reg) ? lat3_reg : worst_reg;
        mean_next     = mean_eff;
        jitter_next   = jitter_reg;
        miss_cnt_next = miss_cnt_reg;
        quo_next      = quo_sum;
        rem_next      = rem_carry ? tldm_pkg::IDX_W'(rem_sum - tldm_pkg::WINDOW_R)
                                  : rem_sum[tldm_pkg::IDX_W-1:0];
        cnt_next      = cnt_reg + tldm_pkg::IDX_W'(1);

        if (done) begin
            quo_next = 32'd0;
            rem_next = '0;
            cnt_next = '0;
        end
        if ((mean_eff != 32'd0) && (dev_sat > jitter_reg)) begin
            jitter_next = dev_sat;
        end
        if (miss3_reg && (miss_cnt_reg != tldm_pkg::MISS_MAX)) begin
            miss_cnt_next = miss_cnt_reg + 8'd1;
        end
    end

    always_comb begin
        out_next.latency       = lat3_reg;
        out_next.worst_latency = worst_next;
        out_next.mean_latency  = mean_next;
        out_next.jitter_peak   = jitter_next;
        out_next.miss_count    = miss_cnt_next;
        out_next.missed        = miss3_reg;
        out_next.window_done   = done;
    end

    // Control and statistics registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            mv_reg       <= 1'b0;
            worst_reg    <= 32'd0;
            mean_reg     <= 32'd0;
            jitter_reg   <= 16'd0;
            miss_cnt_reg <= 8'd0;
            quo_reg      <= 32'd0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            if (ld0) begin
                v0_reg <= s_valid;
            end
            if (ld1) begin
                v1_reg <= v0_reg;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
            if (ld_out) begin
                mv_reg <= v3_reg;
            end
            if (v3_reg && ld_out) begin
                worst_reg    <= worst_next;
                mean_reg     <= mean_next;
                jitter_reg   <= jitter_next;
                miss_cnt_reg <= miss_cnt_next;
                quo_reg      <= quo_next;
                rem_reg      <= rem_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ld0 && s_valid) begin
            in0_reg <= s_data;
        end
        if (ld1 && v0_reg) begin
            lat1_reg  <= lat_next;
            miss1_reg <= miss_next;
        end
        if (ld2 && v1_reg) begin
            lat2_reg  <= lat1_reg;
            miss2_reg <= miss1_reg;
            prod2_reg <= prod_next;
        end
        if (ld3 && v2_reg) begin
            lat3_reg  <= lat2_reg;
            miss3_reg <= miss2_reg;
            quo3_reg  <= quo_part;
            rem3_reg  <= rem_diff[tldm_pkg::IDX_W-1:0];
        end
        if (ld_out && v3_reg) begin
            out_reg <= out_next;
        end
    end

    // The partial remainder of the window sum always stays below WINDOW.
    `TLDM_ASSERT(a_rem_bound, {1'b0, rem_reg} < tldm_pkg::WINDOW_R, "window remainder out of range")

    // An empty window holds no accumulated sum.
    `TLDM_ASSERT_IMP(a_empty_window, cnt_reg == '0, (quo_reg == 32'd0) && (rem_reg == '0), "empty window holds a sum")

    // A completing item shows the new mean in its result.
    `TLDM_ASSERT_NXT(a_done_mean, v3_reg && ld_out && done, m_valid && m_data.window_done && (m_data.mean_latency == $past(quo_sum)), "window mean not delivered")

    // A missed deadline is always reflected in a nonzero miss count.
    `TLDM_ASSERT_IMP(a_miss_counted, m_valid && m_data.missed, m_data.miss_count != 8'd0, "miss not counted")

endmodule

// ===== verif/task_latency_deadline_monitor_test.sv =====
// Self-checking testbench for the task latency deadline monitor.
// Drives task records with random pacing and checks every result against a cycle-free predictor.
// Depends on tldm_pkg and the task_latency_deadline_monitor RTL.
`timescale 1ns / 1ps

module task_latency_deadline_monitor_test;

    // The run is ended by force if it ever gets this far. The slowest correct run is
    // roughly 750 transactions, each waiting out a long sender gap and a receiver stall,
    // plus one long hold-off and one drain pause, which stays well under this limit.
    localparam int LIMIT_CYCLES = 400000;
    // Length of the receiver hold-off that fills the pipeline.
    localparam int HOLD_CYCLES = 150;
    // Quiet cycles after the last result, longer than the pipeline latency.
    localparam int TAIL_CYCLES = 20;
    // Number of mismatches that are reported in full.
    localparam int REPORT_LIMIT = 10;

    // Receiver stall patterns, taken in turn as the phase counter advances.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_COIN
    } rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tldm_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tldm_pkg::out_t m_data;

    task_latency_deadline_monitor uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state. It mirrors the statistics the block keeps and is
    // advanced once for every transaction accepted on the input side.
    // ------------------------------------------------------------------
    logic [31:0] pred_worst = '0;
    logic [31:0] pred_mean = '0;
    logic [15:0] pred_jitter = '0;
    logic [7:0]  pred_misses = '0;
    logic [63:0] pred_sum = '0;
    int          pred_fill = 0;

    // Expected results, oldest first.
    tldm_pkg::out_t expected_stats_q[$];

    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int records_sent = 0;
    int windows_closed = 0;
    int misses_seen = 0;
    int input_stalls = 0;

    // Sender pacing. When gapless is set, the sender offers back to back.
    bit gapless = 1'b0;
    int burst_left = 0;

    // Receiver hold-off requests. The test bumps hold_reqs and the receiver
    // process notices the change and counts the hold-off down by itself.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic [15:0] rx_phase = '0;

    // Advances the statistics by one finished task and returns what the block
    // should report for it. All outputs reflect the state after this update.
    function automatic tldm_pkg::out_t update_latency_stats(tldm_pkg::in_t rec);
        logic [31:0] lat;
        logic [31:0] dev;
        tldm_pkg::out_t res;

        res = '0;
        lat = rec.end_stamp - rec.start_stamp;

        if (lat > pred_worst) begin
            pred_worst = lat;
        end

        pred_sum = pred_sum + 64'(lat);
        pred_fill = pred_fill + 1;
        if (pred_fill >= tldm_pkg::WINDOW) begin
            pred_mean = 32'(pred_sum / 64'(tldm_pkg::WINDOW));
            pred_sum = '0;
            pred_fill = 0;
            res.window_done = 1'b1;
        end

        // Deviation is only tracked once a window has produced a nonzero mean.
        if (pred_mean != 0) begin
            if (lat > pred_mean) begin
                dev = lat - pred_mean;
            end else begin
                dev = pred_mean - lat;
            end
            if (dev > 32'(tldm_pkg::JITTER_MAX)) begin
                dev = 32'(tldm_pkg::JITTER_MAX);
            end
            if (dev[15:0] > pred_jitter) begin
                pred_jitter = dev[15:0];
            end
        end

        // A latency equal to the deadline still counts as on time.
        if (lat > rec.deadline) begin
            res.missed = 1'b1;
            if (pred_misses != tldm_pkg::MISS_MAX) begin
                pred_misses = pred_misses + 8'd1;
            end
        end

        res.latency = lat;
        res.worst_latency = pred_worst;
        res.mean_latency = pred_mean;
        res.jitter_peak = pred_jitter;
        res.miss_count = pred_misses;
        return res;
    endfunction

    // Builds a task record from raw stamps.
    function automatic tldm_pkg::in_t stamp_item(logic [31:0] start_us, logic [31:0] finish_us,
                                                 logic [31:0] allowed_us);
        tldm_pkg::in_t rec;

        rec.start_stamp = start_us;
        rec.end_stamp = finish_us;
        rec.deadline = allowed_us;
        return rec;
    endfunction

    // Builds a task record with a given latency and a random start time, so the
    // end stamp wraps whenever the start happens to sit near the top of the range.
    function automatic tldm_pkg::in_t latency_item(logic [31:0] lat, logic [31:0] allowed_us);
        logic [31:0] start_us;

        start_us = $urandom;
        return stamp_item(start_us, start_us + lat, allowed_us);
    endfunction

    // Inserts an idle gap between bursts unless the current test wants a
    // continuous stream. Gaps are mostly short, with the occasional long one.
    task automatic pace_sender();
        int gap;

        if (!gapless) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 7) == 0) begin
                    gap = $urandom_range(10, 40);
                end else begin
                    gap = $urandom_range(0, 5);
                end
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // Offers one task record and holds it until the block takes it. The record
    // is folded into the predictor at the edge where the transaction happens.
    // Valid is left high on return unless a gap lowered it, so a following record continues the burst.
    task automatic send_task_record(input tldm_pkg::in_t rec);
        s_data <= rec;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_stats_q.push_back(update_latency_stats(rec));
        records_sent++;
        pace_sender();
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_stats_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Field extremes, timestamp wrap and the deadline boundary. Latencies stay
    // small here so that the first windows still leave room for jitter to grow.
    task automatic test_directed_corners();
        send_task_record(stamp_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_task_record(stamp_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_task_record(stamp_item(32'hFFFF_FFF0, 32'h0000_000F, 32'h0000_001F));
        send_task_record(stamp_item(32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_001F));
        send_task_record(stamp_item(32'h0000_0000, 32'h0000_0001, 32'h0000_0000));
        send_task_record(stamp_item(32'h8000_0000, 32'h8000_0FA0, 32'h0000_0FA0));
        send_task_record(stamp_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        send_task_record(stamp_item(32'hAAAA_AAAA, 32'hAAAA_B2AA, 32'h5555_5555));
        send_task_record(stamp_item(32'h5555_5555, 32'h5555_5D55, 32'hAAAA_AAAA));
        send_task_record(stamp_item(32'h1234_5678, 32'h1234_5B60, 32'h0000_04E7));
        send_task_record(stamp_item(32'h1234_5678, 32'h1234_5B60, 32'h0000_04E8));
        send_task_record(stamp_item(32'hFFFF_F000, 32'h0000_0800, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // Well-formed windows: latencies cluster around a base with a spread that
    // widens from one window to the next, so the jitter peak climbs in steps.
    task automatic test_steady_windows();
        int closed;
        int spread;
        int base;
        logic [31:0] lat;

        closed = 0;
        spread = 200;
        base = $urandom_range(2000, 60000);
        while (closed < 2) begin
            lat = 32'(base + $urandom_range(0, spread) - spread / 2);
            send_task_record(latency_item(lat, lat + 32'($urandom_range(0, 200)) - 32'd100));
            if (pred_fill == 0) begin
                closed++;
                spread = spread * 4;
                base = $urandom_range(2000, 60000);
            end
        end
    endtask

    // Deviations right at the saturation point, then the largest latency there is.
    task automatic test_jitter_limit();
        send_task_record(latency_item(pred_mean + 32'd65534, $urandom));
        send_task_record(latency_item(pred_mean + 32'd65535, $urandom));
        send_task_record(latency_item(pred_mean + 32'd65536, $urandom));
        send_task_record(stamp_item(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFE));
        send_task_record(stamp_item(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // Closes the open window, then runs a whole window whose sum is below the
    // window length so the mean drops to zero and jitter tracking pauses.
    task automatic test_zero_mean_window();
        int ones;

        while (pred_fill != 0) begin
            send_task_record(latency_item(32'd0, $urandom));
        end
        ones = 0;
        do begin
            if (ones < 50 && $urandom_range(0, 9) == 0) begin
                ones++;
                send_task_record(latency_item(32'd1, $urandom_range(0, 1)));
            end else begin
                send_task_record(latency_item(32'd0, $urandom));
            end
        end while (pred_fill != 0);
        // A few records with a zero mean in force; jitter must hold still.
        repeat (10) begin
            send_task_record(latency_item(32'($urandom_range(0, 1000000)), $urandom));
        end
    endtask

    // The receiver holds off for a long stretch while the sender streams, so the
    // pipeline fills and the input side has to stall.
    task automatic test_output_backpressure();
        gapless = 1'b1;
        hold_reqs <= hold_reqs + 1;
        repeat (40) begin
            send_task_record(latency_item(32'($urandom_range(0, 200000)), $urandom));
        end
        gapless = 1'b0;
    endtask

    // The sender pauses until every result has come back, then carries on.
    task automatic test_drain_pause();
        repeat (20) begin
            send_task_record(latency_item(32'($urandom_range(0, 50000)), $urandom));
        end
        wait_drained();
        repeat (20) begin
            send_task_record(latency_item(32'($urandom_range(0, 50000)), $urandom));
        end
    endtask

    // Drives the miss counter into saturation and keeps missing past it.
    task automatic test_miss_saturation();
        logic [31:0] lat;
        int extra;

        extra = 0;
        while (extra < 20) begin
            lat = 32'($urandom_range(1, 100000));
            if ($urandom_range(0, 4) == 0) begin
                send_task_record(latency_item(lat, lat + 32'($urandom_range(0, 10))));
            end else begin
                send_task_record(latency_item(lat, 32'($urandom_range(0, lat - 1))));
            end
            if (pred_misses == tldm_pkg::MISS_MAX) begin
                extra++;
            end
        end
    endtask

    // Unrestricted records: any latency from zero to full scale, deadlines on
    // and around the latency as well as anywhere in range.
    task automatic test_random_mix();
        int pick;
        logic [31:0] lat;
        logic [31:0] allowed;

        repeat (60) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                lat = 32'($urandom_range(0, 5000));
            end else if (pick < 60) begin
                lat = 32'($urandom_range(0, 32'h00FF_FFFF));
            end else if (pick < 85) begin
                lat = $urandom;
            end else if (pick < 93) begin
                lat = 32'hFFFF_FFFF;
            end else begin
                lat = '0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                allowed = lat;
            end else if (pick < 35) begin
                allowed = lat - 32'd1;
            end else if (pick < 50) begin
                allowed = lat + 32'd1;
            end else if (pick < 90) begin
                allowed = $urandom;
            end else if (pick < 95) begin
                allowed = '0;
            end else begin
                allowed = 32'hFFFF_FFFF;
            end

            // Part of the stream runs without any sender gaps.
            gapless = ($urandom_range(0, 3) == 0);
            send_task_record(latency_item(lat, allowed));
        end
        gapless = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, overridden by hold-off requests.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 16'd1;
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode_t'(rx_phase[9:8]))
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_SPARSE: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                RX_PERIODIC: begin
                    m_ready <= (rx_phase[2:0] < 3'd5);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 1) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checking: every transaction on the output side is compared
    // field by field with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("Mismatch on result %0d, %s: expected %0d (0x%08h), got %0d (0x%08h)",
                         results_checked, field, want, want, got, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        tldm_pkg::out_t want;

        if (aresetn && m_valid && m_ready) begin
            if (expected_stats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected result with latency %0d and no record pending",
                             m_data.latency);
                end
            end else begin
                want = expected_stats_q.pop_front();
                compare_field("latency", want.latency, m_data.latency);
                compare_field("worst_latency", want.worst_latency, m_data.worst_latency);
                compare_field("mean_latency", want.mean_latency, m_data.mean_latency);
                compare_field("jitter_peak", 32'(want.jitter_peak), 32'(m_data.jitter_peak));
                compare_field("miss_count", 32'(want.miss_count), 32'(m_data.miss_count));
                compare_field("missed", 32'(want.missed), 32'(m_data.missed));
                compare_field("window_done", 32'(want.window_done), 32'(m_data.window_done));
                windows_closed += int'(want.window_done);
                misses_seen += int'(want.missed);
            end
            results_checked++;
        end
    end

    // Cycle counter and input stall tally.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_valid && !s_ready) begin
            input_stalls <= input_stalls + 1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_stats_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_steady_windows();
        test_jitter_limit();
        test_zero_mean_window();
        test_output_backpressure();
        test_drain_pause();
        test_miss_saturation();
        test_random_mix();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d task records and checked %0d results over %0d cycles.",
                 records_sent, results_checked, cycle_count);
        $display("Windows closed: %0d, deadline misses: %0d, input stall cycles: %0d.",
                 windows_closed, misses_seen, input_stalls);
        if (mismatches == 0 && expected_stats_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, expected_stats_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tldm_pkg.sv
hdl/task_latency_deadline_monitor.sv
verif/task_latency_deadline_monitor_test.sv
